// ===== sv/image_stripe_bitstream_decoder_defines.svh =====
// assertion helpers for the stripe decoder checker
`ifndef IMAGE_STRIPE_BITSTREAM_DECODER_DEFINES_SVH
`define IMAGE_STRIPE_BITSTREAM_DECODER_DEFINES_SVH

// same-cycle implication, reset-qualified
`define ISBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define ISBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/isbd_pkg.sv =====
package isbd_pkg;

    localparam int STRIPE_WIDTH    = 8;
    localparam int MAX_HEIGHT_DEF  = 1023;
    localparam int RESULT_LIMIT    = 10;
    localparam int BUF_W           = 24;
    localparam int CNT_W           = 5;
    localparam int HEIGHT_W        = 10;
    localparam int COLOR_W         = 8;
    localparam int LEN_W           = 9;
    localparam int RES_CNT_W       = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_HEIGHT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENCY_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        METHOD_A = 2'd0,
        METHOD_B = 2'd1,
        METHOD_C = 2'd2
    } method_t;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_COLOR = 2'd1,
        PH_BITS  = 2'd2
    } phase_t;

    // commands from controller to datapath
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_LATCH  = 3'd1,
        CMD_TYPE   = 3'd2,
        CMD_COLOR  = 3'd3,
        CMD_APPEND = 3'd4,
        CMD_CODE   = 3'd5
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic start_flag;
        logic phase_color;
        logic phase_bits;
        logic slot_free;
        logic code_ready;
        logic code_last;
    } status_t;

    // one result beat
    typedef struct packed {
        logic [COLOR_W-1:0] run_color;
        logic [LEN_W-1:0]   run_length;
        logic               skip_pixels;
        logic               column_order;
        logic               stripe_done;
        logic               bad_type;
        logic               last_of_byte;
    } out_item_t;

    // true when the buffered bits hold a whole code
    function automatic logic code_complete(input logic [BUF_W-1:0] b,
                                           input logic [CNT_W-1:0] c,
                                           input method_t m,
                                           input logic [3:0] lw);
        logic ok;
        ok = 1'b0;
        if (c == 5'd0)
            ok = 1'b0;
        else if (!b[0])
            ok = 1'b1;
        else if (c < 5'd2)
            ok = 1'b0;
        else if (!b[1])
            ok = (c >= ({1'b0, lw} + 5'd2));
        else if (m == METHOD_A)
        begin
            if (c < 5'd5)
                ok = 1'b0;
            else if (b[4:2] != 3'd4)
                ok = 1'b1;
            else
                ok = (c >= 5'd13);
        end
        else
            ok = (c >= 5'd3);
        return ok;
    endfunction

endpackage

// ===== sv/isbd_in_if.sv =====
interface isbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [isbd_pkg::COLOR_W-1:0] src_byte;
    logic                        start_stripe;

    modport source (output valid, output src_byte, output start_stripe, input ready);
    modport sink (input valid, input src_byte, input start_stripe, output ready);
endinterface

// ===== sv/isbd_out_if.sv =====
interface isbd_out_if;
    logic                         valid;
    logic                         ready;
    logic [isbd_pkg::COLOR_W-1:0] run_color;
    logic [isbd_pkg::LEN_W-1:0]   run_length;
    logic                         skip_pixels;
    logic                         column_order;
    logic                         stripe_done;
    logic                         bad_type;
    logic                         last_of_byte;

    modport source (output valid, output run_color, output run_length, output skip_pixels,
                    output column_order, output stripe_done, output bad_type,
                    output last_of_byte, input ready);
    modport sink (input valid, input run_color, input run_length, input skip_pixels,
                  input column_order, input stripe_done, input bad_type,
                  input last_of_byte, output ready);
endinterface

// ===== sv/isbd_ctrl.sv =====
module isbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  isbd_pkg::status_t status,
    output isbd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_CODE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // sequencing of byte load and code walk
    always_comb
    begin
        state_next = state_reg;
        cmd        = isbd_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = isbd_pkg::CMD_LATCH;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.start_flag)
                begin
                    if (status.slot_free)
                    begin
                        cmd        = isbd_pkg::CMD_TYPE;
                        state_next = S_IDLE;
                    end
                end
                else if (status.phase_color)
                begin
                    if (status.slot_free)
                    begin
                        cmd        = isbd_pkg::CMD_COLOR;
                        state_next = S_IDLE;
                    end
                end
                else if (status.phase_bits)
                begin
                    cmd        = isbd_pkg::CMD_APPEND;
                    state_next = S_CODE;
                end
                else
                    state_next = S_IDLE;
            end
            S_CODE:
            begin
                if (!status.code_ready)
                    state_next = S_IDLE;
                else if (status.slot_free)
                begin
                    cmd = isbd_pkg::CMD_CODE;
                    if (status.code_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/isbd_datapath.sv =====
module isbd_datapath #(
    parameter int MAX_HEIGHT = isbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  isbd_pkg::cmd_t                   cmd,
    input  logic [isbd_pkg::COLOR_W-1:0]     src_byte,
    input  logic                             start_stripe,
    input  logic                             cfg_write,
    input  logic [isbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [isbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output isbd_pkg::out_item_t              out_item,
    output isbd_pkg::status_t                status
);

    localparam int PL_W  = $clog2(isbd_pkg::STRIPE_WIDTH * MAX_HEIGHT + 1);
    localparam int MH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W = (MH_W > isbd_pkg::HEIGHT_W) ? MH_W : isbd_pkg::HEIGHT_W;
    localparam int LC_W  = (PL_W > isbd_pkg::LEN_W) ? PL_W : isbd_pkg::LEN_W;
    localparam int SW_SH = $clog2(isbd_pkg::STRIPE_WIDTH);

    // configuration
    logic [isbd_pkg::HEIGHT_W-1:0] height_reg;
    logic [isbd_pkg::COLOR_W-1:0]  tcolor_reg;
    logic                          tenable_reg;

    // decoder state
    logic [isbd_pkg::BUF_W-1:0]     buf_reg, buf_next;
    logic [isbd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [isbd_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic                           delta_reg, delta_next;
    logic [PL_W-1:0]                pl_reg, pl_next;
    isbd_pkg::method_t              method_reg, method_next;
    logic [3:0]                     lw_reg, lw_next;
    logic                           tact_reg, tact_next;
    isbd_pkg::phase_t               phase_reg, phase_next;
    logic [isbd_pkg::RES_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic                           ovalid_reg, ovalid_next;

    // latched input beat
    logic [isbd_pkg::COLOR_W-1:0] byte_reg;
    logic                         start_reg;

    isbd_pkg::out_item_t item_reg, item_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg  <= 10'd1;
            tcolor_reg  <= '0;
            tenable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                isbd_pkg::REG_STRIPE_HEIGHT:       height_reg  <= cfg_data;
                isbd_pkg::REG_TRANSPARENT_COLOR:   tcolor_reg  <= cfg_data[7:0];
                isbd_pkg::REG_TRANSPARENCY_ENABLE: tenable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // code decode on the buffered bits
    logic [3:0]                   dec_use;
    logic [isbd_pkg::COLOR_W-1:0] dec_color;
    logic                         dec_delta;
    logic [isbd_pkg::LEN_W-1:0]   dec_run;
    logic [isbd_pkg::COLOR_W-1:0] lit_mask;
    logic                         dd;

    always_comb
    begin
        lit_mask  = (lw_reg >= 4'd8) ? 8'hFF : 8'((9'd1 << lw_reg[2:0]) - 9'd1);
        dec_use   = 4'd1;
        dec_color = color_reg;
        dec_delta = delta_reg;
        dec_run   = 9'd1;
        dd        = delta_reg ^ buf_reg[2];
        if (buf_reg[0])
        begin
            if (!buf_reg[1])
            begin
                dec_use   = lw_reg + 4'd2;
                dec_color = buf_reg[9:2] & lit_mask;
                if (method_reg != isbd_pkg::METHOD_A)
                    dec_delta = 1'b1;
            end
            else if (method_reg == isbd_pkg::METHOD_A)
            begin
                if (buf_reg[4:2] != 3'd4)
                begin
                    dec_use   = 4'd5;
                    dec_color = color_reg + {5'd0, buf_reg[4:2]} + 8'd252;
                end
                else
                begin
                    dec_use = 4'd13;
                    dec_run = (buf_reg[12:5] == 8'd0) ? 9'd256 : {1'b0, buf_reg[12:5]};
                end
            end
            else
            begin
                dec_use   = 4'd3;
                dec_delta = dd;
                dec_color = color_reg + (dd ? 8'hFF : 8'h01);
            end
        end
    end

    // run length clip against the pixels left
    logic [isbd_pkg::LEN_W-1:0]   run_len;
    logic [LC_W-1:0]              clip_len;
    logic [PL_W-1:0]              pl_after;
    logic                         run_done;
    logic [isbd_pkg::BUF_W-1:0]   code_buf;
    logic [isbd_pkg::CNT_W-1:0]   code_cnt;
    logic                         cur_complete, next_complete;

    always_comb
    begin
        run_len  = (cmd == isbd_pkg::CMD_COLOR) ? 9'd1 : dec_run;
        clip_len = LC_W'(run_len);
        if (clip_len > LC_W'(pl_reg))
            clip_len = LC_W'(pl_reg);
        pl_after = pl_reg - PL_W'(clip_len);
        run_done = (pl_after == '0);
        code_buf = buf_reg >> dec_use;
        code_cnt = cnt_reg - isbd_pkg::CNT_W'(dec_use);
        cur_complete  = isbd_pkg::code_complete(buf_reg, cnt_reg, method_reg, lw_reg);
        next_complete = isbd_pkg::code_complete(code_buf, code_cnt, method_reg, lw_reg);
    end

    // type byte decode
    logic [4:0]         grp;
    logic [3:0]         wid;
    logic               type_ok;
    logic               type_trans;
    isbd_pkg::method_t  type_method;
    logic [CMP_W-1:0]   h_sat;

    always_comb
    begin
        grp         = 5'((16'(byte_reg) * 16'd205) >> 11);
        wid         = 4'(byte_reg - 8'({3'd0, grp} * 8'd10));
        type_ok     = (wid inside {[4'd4:4'd8]});
        type_trans  = 1'b0;
        type_method = isbd_pkg::METHOD_A;
        case (grp)
            5'd1:  type_method = isbd_pkg::METHOD_C;
            5'd3:
            begin
                type_method = isbd_pkg::METHOD_C;
                type_trans  = 1'b1;
            end
            5'd2:  type_method = isbd_pkg::METHOD_B;
            5'd4:
            begin
                type_method = isbd_pkg::METHOD_B;
                type_trans  = 1'b1;
            end
            5'd6, 5'd10: type_method = isbd_pkg::METHOD_A;
            5'd8, 5'd12:
            begin
                type_method = isbd_pkg::METHOD_A;
                type_trans  = 1'b1;
            end
            default: type_ok = 1'b0;
        endcase
        h_sat = CMP_W'(height_reg);
        if (h_sat == '0)
            h_sat = CMP_W'(1);
        if (h_sat > CMP_W'(MAX_HEIGHT))
            h_sat = CMP_W'(MAX_HEIGHT);
    end

    // state update per command
    always_comb
    begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        color_next  = color_reg;
        delta_next  = delta_reg;
        pl_next     = pl_reg;
        method_next = method_reg;
        lw_next     = lw_reg;
        tact_next   = tact_reg;
        phase_next  = phase_reg;
        rcnt_next   = rcnt_reg;
        item_next   = item_reg;
        ovalid_next = ovalid_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        case (cmd)
            isbd_pkg::CMD_TYPE:
            begin
                buf_next = '0;
                cnt_next = '0;
                if (!type_ok)
                begin
                    method_next = isbd_pkg::METHOD_A;
                    lw_next     = '0;
                    tact_next   = 1'b0;
                    pl_next     = '0;
                    phase_next  = isbd_pkg::PH_WAIT;
                    item_next   = '0;
                    item_next.stripe_done  = 1'b1;
                    item_next.bad_type     = 1'b1;
                    item_next.last_of_byte = 1'b1;
                    ovalid_next = 1'b1;
                end
                else
                begin
                    method_next = type_method;
                    lw_next     = wid;
                    tact_next   = type_trans & tenable_reg;
                    pl_next     = PL_W'(h_sat) << SW_SH;
                    delta_next  = 1'b1;
                    phase_next  = isbd_pkg::PH_COLOR;
                end
            end
            isbd_pkg::CMD_COLOR:
            begin
                color_next  = byte_reg;
                phase_next  = isbd_pkg::PH_BITS;
                pl_next     = pl_after;
                item_next.run_color    = byte_reg;
                item_next.run_length   = isbd_pkg::LEN_W'(clip_len);
                item_next.skip_pixels  = tact_reg & (byte_reg == tcolor_reg);
                item_next.column_order = (method_reg == isbd_pkg::METHOD_C);
                item_next.stripe_done  = run_done;
                item_next.bad_type     = 1'b0;
                item_next.last_of_byte = 1'b1;
                ovalid_next = 1'b1;
                if (run_done)
                begin
                    phase_next = isbd_pkg::PH_WAIT;
                    buf_next   = '0;
                    cnt_next   = '0;
                end
            end
            isbd_pkg::CMD_APPEND:
            begin
                buf_next  = buf_reg | (isbd_pkg::BUF_W'(byte_reg) << cnt_reg[3:0]);
                cnt_next  = cnt_reg + 5'd8;
                rcnt_next = '0;
            end
            isbd_pkg::CMD_CODE:
            begin
                buf_next   = code_buf;
                cnt_next   = code_cnt;
                color_next = dec_color;
                delta_next = dec_delta;
                pl_next    = pl_after;
                rcnt_next  = rcnt_reg + 4'd1;
                item_next.run_color    = dec_color;
                item_next.run_length   = isbd_pkg::LEN_W'(clip_len);
                item_next.skip_pixels  = tact_reg & (dec_color == tcolor_reg);
                item_next.column_order = (method_reg == isbd_pkg::METHOD_C);
                item_next.stripe_done  = run_done;
                item_next.bad_type     = 1'b0;
                item_next.last_of_byte = status.code_last;
                ovalid_next = 1'b1;
                if (run_done)
                begin
                    phase_next = isbd_pkg::PH_WAIT;
                    buf_next   = '0;
                    cnt_next   = '0;
                end
            end
            default: ;
        endcase
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg    <= '0;
            cnt_reg    <= '0;
            color_reg  <= '0;
            delta_reg  <= 1'b1;
            pl_reg     <= '0;
            method_reg <= isbd_pkg::METHOD_A;
            lw_reg     <= '0;
            tact_reg   <= 1'b0;
            phase_reg  <= isbd_pkg::PH_WAIT;
            rcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            color_reg  <= color_next;
            delta_reg  <= delta_next;
            pl_reg     <= pl_next;
            method_reg <= method_next;
            lw_reg     <= lw_next;
            tact_reg   <= tact_next;
            phase_reg  <= phase_next;
            rcnt_reg   <= rcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (cmd == isbd_pkg::CMD_LATCH)
        begin
            byte_reg  <= src_byte;
            start_reg <= start_stripe;
        end
    end

    // status towards the controller
    always_comb
    begin
        status.start_flag  = start_reg;
        status.phase_color = (phase_reg == isbd_pkg::PH_COLOR);
        status.phase_bits  = (phase_reg == isbd_pkg::PH_BITS);
        status.slot_free   = !ovalid_reg || out_ready;
        status.code_ready  = (phase_reg == isbd_pkg::PH_BITS) &&
                             (rcnt_reg < 4'(isbd_pkg::RESULT_LIMIT)) && cur_complete;
        status.code_last   = run_done || (rcnt_reg == 4'(isbd_pkg::RESULT_LIMIT - 1)) ||
                             !next_complete;
    end

    assign out_valid = ovalid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/image_stripe_bitstream_decoder.sv =====
// Stripe decoder: takes one stripe byte per input beat (type byte marked by start_stripe,
// then the start colour, then the bitstream) and gives one output beat per run of one
// colour, with last_of_byte on the final run a byte causes. A byte is latched when taken
// and handled in the load state; a type or colour byte is then done once the output slot
// is free, and a bitstream byte moves on to the code walk, where the code decoder handles
// one code per cycle while the output slot is free, giving up to 10 runs per byte. The next
// byte is accepted while the last run still waits in the output register.
// Configuration is to be written through cfg_write/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
module image_stripe_bitstream_decoder #(
    parameter int MAX_HEIGHT = isbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [isbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [isbd_pkg::CFG_DATA_W-1:0] cfg_data,
    isbd_in_if.sink                         in_ch,
    isbd_out_if.source                      out_ch
);

    isbd_pkg::cmd_t      cmd;
    isbd_pkg::status_t   status;
    isbd_pkg::out_item_t out_item;

    // controller
    isbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    isbd_datapath #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .src_byte     (in_ch.src_byte),
        .start_stripe (in_ch.start_stripe),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_item     (out_item),
        .status       (status)
    );

    // result beat onto the output channel
    assign out_ch.run_color    = out_item.run_color;
    assign out_ch.run_length   = out_item.run_length;
    assign out_ch.skip_pixels  = out_item.skip_pixels;
    assign out_ch.column_order = out_item.column_order;
    assign out_ch.stripe_done  = out_item.stripe_done;
    assign out_ch.bad_type     = out_item.bad_type;
    assign out_ch.last_of_byte = out_item.last_of_byte;

endmodule

// ===== sv/isbd_checker.sv =====
`include "image_stripe_bitstream_decoder_defines.svh"

module isbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] run_color,
    input logic [8:0] run_length,
    input logic       skip_pixels,
    input logic       column_order,
    input logic       stripe_done,
    input logic       bad_type,
    input logic       last_of_byte
);

    // a stalled result beat holds
    `ISBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({run_color, run_length, skip_pixels, column_order, stripe_done, bad_type, last_of_byte}), "stalled result beat changed")

    // a taken byte is loaded before the next is taken
    `ISBD_ASSERT_NEXT(a_in_gap, clk, rst_n, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

    // unknown type ends the stripe with an empty result
    `ISBD_ASSERT_IMP(a_bad_type, clk, rst_n, out_valid && bad_type, stripe_done && last_of_byte && run_length == 9'd0 && run_color == 8'd0 && !skip_pixels && !column_order, "bad type beat malformed")

    // a real run has length from one to 256
    `ISBD_ASSERT_IMP(a_run_len, clk, rst_n, out_valid && !bad_type, run_length != 9'd0 && (run_length[8] == 1'b0 || run_length[7:0] == 8'd0), "run length out of range")

endmodule

bind image_stripe_bitstream_decoder isbd_checker u_isbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .run_color    (out_ch.run_color),
    .run_length   (out_ch.run_length),
    .skip_pixels  (out_ch.skip_pixels),
    .column_order (out_ch.column_order),
    .stripe_done  (out_ch.stripe_done),
    .bad_type     (out_ch.bad_type),
    .last_of_byte (out_ch.last_of_byte)
);

// ===== bench/isbd_run_checker.sv =====
module isbd_run_checker
    import isbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COLOR_W-1:0]    in_byte,
    input  logic                  in_start,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_run,
    output int                    fail_count,
    output int                    runs_pending,
    output int                    runs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [HEIGHT_W-1:0] height_reg;
    logic [COLOR_W-1:0]  key_color_reg;
    logic                key_enable_reg;

    // decoder state copy
    logic [BUF_W-1:0]    bits_q;
    logic [CNT_W-1:0]    nbits;
    logic [COLOR_W-1:0]  colour;
    logic                step_down;
    logic [12:0]         pix_left;
    method_t             meth;
    logic [3:0]          lit_w;
    logic                key_active;
    phase_t              ph;

    out_item_t expected_runs[$];

    // queue one run of the current colour
    function automatic void queue_run(logic [LEN_W-1:0] len, logic done, logic bad);
        out_item_t r;
        r = '0;
        if (!bad)
        begin
            r.run_color    = colour;
            r.run_length   = len;
            r.skip_pixels  = key_active && (colour == key_color_reg);
            r.column_order = (meth == METHOD_C);
        end
        r.stripe_done = done;
        r.bad_type    = bad;
        expected_runs.push_back(r);
    endfunction

    // clip a run to the stripe and close the stripe when full
    function automatic void place_run(logic [LEN_W-1:0] len);
        logic [12:0] l;
        l = {4'd0, len};
        if (l > pix_left)
            l = pix_left;
        pix_left = pix_left - l;
        queue_run(l[LEN_W-1:0], pix_left == 0, 1'b0);
        if (pix_left == 0)
        begin
            ph     = PH_WAIT;
            bits_q = '0;
            nbits  = '0;
        end
    endfunction

    function automatic void take_type(logic [7:0] t);
        int grp, w, h;
        logic ok, key;
        grp = t / 10;
        w   = t % 10;
        ok  = (w >= 4 && w <= 8);
        key = (grp == 3 || grp == 4 || grp == 8 || grp == 12);
        if (grp == 1 || grp == 3)
            meth = METHOD_C;
        else if (grp == 2 || grp == 4)
            meth = METHOD_B;
        else if (grp == 6 || grp == 10 || grp == 8 || grp == 12)
            meth = METHOD_A;
        else
            ok = 1'b0;
        bits_q = '0;
        nbits  = '0;
        if (!ok)
        begin
            meth       = METHOD_A;
            lit_w      = '0;
            key_active = 1'b0;
            pix_left   = '0;
            ph         = PH_WAIT;
            queue_run('0, 1'b1, 1'b1);
        end
        else
        begin
            lit_w      = w[3:0];
            key_active = key && key_enable_reg;
            h = height_reg;
            if (h == 0)
                h = 1;
            pix_left  = 13'(STRIPE_WIDTH * h);
            step_down = 1'b1;
            ph        = PH_COLOR;
        end
    endfunction

    // decode the whole codes now in the bit buffer, up to RESULT_LIMIT per byte
    function automatic void take_bits(logic [7:0] b);
        int n, used;
        logic [8:0] run;
        logic [7:0] mask, v;
        n = 0;
        bits_q = bits_q | (BUF_W'(b) << (nbits & 5'd15));
        nbits  = nbits + 5'd8;
        mask   = (lit_w >= 8) ? 8'hFF : 8'((1 << lit_w) - 1);
        while (ph == PH_BITS && n < RESULT_LIMIT)
        begin
            run = 9'd0;
            if (nbits < 1)
                break;
            if (!bits_q[0])
                used = 1;
            else
            begin
                if (nbits < 2)
                    break;
                if (!bits_q[1])
                begin
                    used = 2 + lit_w;
                    if (nbits < used)
                        break;
                    colour = 8'(bits_q >> 2) & mask;
                    if (meth != METHOD_A)
                        step_down = 1'b1;
                end
                else if (meth == METHOD_A)
                begin
                    if (nbits < 5)
                        break;
                    v = {5'd0, bits_q[4:2]};
                    if (v != 8'd4)
                    begin
                        used   = 5;
                        colour = colour + v - 8'd4;
                    end
                    else
                    begin
                        used = 13;
                        if (nbits < 13)
                            break;
                        run = {1'b0, bits_q[12:5]};
                        if (run == 0)
                            run = 9'd256;
                    end
                end
                else
                begin
                    if (nbits < 3)
                        break;
                    if (bits_q[2])
                        step_down = !step_down;
                    used   = 3;
                    colour = step_down ? colour - 8'd1 : colour + 8'd1;
                end
            end
            bits_q = bits_q >> used;
            nbits  = nbits - 5'(used);
            place_run(run != 0 ? run : 9'd1);
            n++;
        end
    endfunction

    function automatic void predict_beat(logic [7:0] b, logic start);
        int prior_count;
        prior_count = expected_runs.size();
        if (start)
            take_type(b);
        else if (ph == PH_COLOR)
        begin
            colour = b;
            ph     = PH_BITS;
            place_run(9'd1);
        end
        else if (ph == PH_BITS)
            take_bits(b);
        if (expected_runs.size() > prior_count)
            expected_runs[expected_runs.size()-1].last_of_byte = 1'b1;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign runs_pending = expected_runs.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            height_reg     <= 10'd1;
            key_color_reg  <= '0;
            key_enable_reg <= 1'b0;
            bits_q = '0; nbits = '0; colour = '0; step_down = 1'b1;
            pix_left = '0; meth = METHOD_A; lit_w = '0; key_active = 1'b0;
            ph = PH_WAIT;
            fail_count = 0;
            runs_seen  = 0;
            expected_runs.delete();
        end
        else
        begin
            // register writes
            if (cfg_write)
            begin
                if (cfg_index == REG_STRIPE_HEIGHT)
                    height_reg <= cfg_data;
                else if (cfg_index == REG_TRANSPARENT_COLOR)
                    key_color_reg <= cfg_data[7:0];
                else if (cfg_index == REG_TRANSPARENCY_ENABLE)
                    key_enable_reg <= cfg_data[0];
            end
            // input beat
            if (in_valid && in_ready)
                predict_beat(in_byte, in_start);
            // output beat
            if (out_valid && out_ready)
            begin
                runs_seen++;
                if (expected_runs.size() == 0)
                begin
                    $error("run beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_runs.pop_front();
                    check_field("run_color", e.run_color, out_run.run_color);
                    check_field("run_length", e.run_length, out_run.run_length);
                    check_field("skip_pixels", e.skip_pixels, out_run.skip_pixels);
                    check_field("column_order", e.column_order, out_run.column_order);
                    check_field("stripe_done", e.stripe_done, out_run.stripe_done);
                    check_field("bad_type", e.bad_type, out_run.bad_type);
                    check_field("last_of_byte", e.last_of_byte, out_run.last_of_byte);
                end
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    import isbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {CODE_KEEP, CODE_LIT, CODE_STEP, CODE_FLIP, CODE_RUN} code_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_STRIPE_HEIGHT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count, runs_pending, runs_seen;
    int                    cycles = 0;
    int                    bytes_sent = 0;
    int                    stripes_sent = 0;
    logic                  quiet = 1'b0;
    logic                  hold_off = 1'b0;
    logic                  bits[$];

    isbd_in_if  in_ch();
    isbd_out_if out_ch();

    image_stripe_bitstream_decoder dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    isbd_run_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_byte(in_ch.src_byte), .in_start(in_ch.start_stripe),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_run({out_ch.run_color, out_ch.run_length, out_ch.skip_pixels,
                  out_ch.column_order, out_ch.stripe_done, out_ch.bad_type,
                  out_ch.last_of_byte}),
        .fail_count(fail_count), .runs_pending(runs_pending), .runs_seen(runs_seen)
    );

    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.src_byte     = '0;
        in_ch.start_stripe = 1'b0;
        out_ch.ready       = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("** image_stripe_bitstream_decoder: FAILED **");
            $finish;
        end
    end

    // receiver: random ready bursts, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (quiet || $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 20);
                out_ch.ready <= 1'b1;
                repeat (n) @(posedge clk);
                n = $urandom_range(1, 13);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // one input beat, then maybe a gap
    task automatic send_byte(logic [7:0] b, logic start);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.src_byte     <= b;
        in_ch.start_stripe <= start;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid, then wait until every predicted run has come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (runs_pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_regs(int h, int key, int en);
        settle();
        write_reg(REG_STRIPE_HEIGHT, h);
        write_reg(REG_TRANSPARENT_COLOR, key);
        write_reg(REG_TRANSPARENCY_ENABLE, en);
    endtask

    function automatic void put_bits(int val, int n);
        for (int i = 0; i < n; i++)
            bits.push_back(val[i]);
    endfunction

    // one stripe: type, colour, then ncodes codes; runs_only gives 256-pixel runs for method A types
    task automatic send_stripe(logic [7:0] t, int ncodes, bit runs_only, bit abort);
        code_kind_t k;
        int w, v;
        logic [7:0] b;
        bit meth_a;
        w = t % 10;
        meth_a = (t / 10 == 6 || t / 10 == 8 || t / 10 == 10 || t / 10 == 12);
        stripes_sent++;
        send_byte(t, 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        bits.delete();
        for (int i = 0; i < ncodes; i++)
        begin
            k = code_kind_t'($urandom_range(0, 4));
            if (runs_only)
                k = CODE_RUN;
            case (k)
                CODE_KEEP: put_bits(0, 1);
                CODE_LIT:
                begin
                    put_bits(1, 2);
                    put_bits($urandom_range(0, 255), w);
                end
                CODE_STEP:
                    if (meth_a)
                    begin
                        put_bits(3, 2);
                        v = $urandom_range(0, 6);
                        put_bits(v >= 4 ? v + 1 : v, 3);
                    end
                    else
                        put_bits(3, 3);
                CODE_FLIP: put_bits(7, 3);
                default:
                    if (meth_a)
                    begin
                        put_bits(3 | (4 << 2), 5);
                        put_bits(runs_only ? 0 : $urandom_range(0, 255), 8);
                    end
                    else
                        put_bits(7, 3);
            endcase
        end
        while (bits.size() % 8 != 0)
            bits.push_back(1'($urandom_range(0, 1)));
        while (bits.size() != 0)
        begin
            for (int i = 0; i < 8; i++)
                b[i] = bits.pop_front();
            if (abort && bits.size() < 16)
                break;
            send_byte(b, 1'b0);
        end
    endtask

    function automatic logic [7:0] good_type();
        int grps[8] = '{1, 2, 3, 4, 6, 8, 10, 12};
        return 8'(grps[$urandom_range(0, 7)] * 10 + $urandom_range(4, 8));
    endfunction

    initial
    begin
        int start_bytes;
        bit held;
        held = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown types, stray byte, each method, keyed types, long runs
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'd53, 1'b1);
        send_byte(8'd19, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_stripe(8'd14, 6, 0, 0);
        send_stripe(8'd28, 6, 0, 0);
        set_regs(0, 255, 1);
        send_stripe(8'd64, 6, 0, 0);
        send_stripe(8'd38, 4, 0, 0);
        set_regs(2, 0, 1);
        send_stripe(8'd124, 10, 0, 0);
        send_stripe(8'd44, 10, 0, 1);
        send_stripe(8'd88, 10, 0, 0);
        set_regs(1023, 128, 0);
        send_stripe(8'd104, 3, 1, 0);
        set_regs(40, 128, 0);
        send_stripe(8'd104, 3, 1, 0);

        // random stripes, with a long receiver stall early on
        set_regs(1, 0, 0);
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 60)
        begin
            if (!held && bytes_sent - start_bytes > 10)
            begin
                hold_off = 1'b1;
                held     = 1'b1;
            end
            if (bytes_sent - start_bytes > 45)
                quiet = 1'b1;
            if ($urandom_range(0, 5) == 0)
                set_regs($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1: send_stripe(good_type(), $urandom_range(2, 12), 0, 1);
                default: send_stripe(good_type(), $urandom_range(4, 30), 0, 0);
            endcase
        end

        settle();
        $display("stripes sent: %0d, bytes: %0d, runs checked: %0d",
                 stripes_sent, bytes_sent, runs_seen);
        if (fail_count == 0)
            $display("** image_stripe_bitstream_decoder: PASSED **");
        else
            $display("** image_stripe_bitstream_decoder: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/isbd_pkg.sv
sv/isbd_in_if.sv
sv/isbd_out_if.sv
sv/isbd_ctrl.sv
sv/isbd_datapath.sv
sv/image_stripe_bitstream_decoder.sv
sv/isbd_checker.sv
bench/isbd_run_checker.sv
bench/tb.sv
